// ----- hdl/polyline_gap_fill_raster_assert.svh -----
// Assertion macros for the polyline gap fill plotter.
`ifndef POLYLINE_GAP_FILL_RASTER_ASSERT_SVH
`define POLYLINE_GAP_FILL_RASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PGF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pgf check failed");

// Next-cycle implication, checked outside reset.
`define PGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pgf check failed");

`endif

// ----- hdl/pgf_raster_pkg.sv -----
// Package: types, codes and defaults of the polyline gap fill plotter.
`timescale 1ns / 1ps
package pgf_raster_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_COLOR_BITS = 8;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_PLOT  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXEL_SCALE  = 2'd2;

    localparam logic [8:0]  RST_FRAME_WIDTH  = 9'd256;
    localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd256;
    localparam logic [31:0] RST_PIXEL_SCALE  = 32'd65536;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_MX, S_MY, S_CHK, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_SQE,
        S_BM, S_STEP, S_DIV, S_FW, S_RD1, S_RD2, S_DONE
    } t_state;

endpackage

// ----- hdl/polyline_gap_fill_raster.sv -----
// Top level: frame store plotter with blended gap fill between polyline points.
`timescale 1ns / 1ps
// Command block: a command is taken when start is high and busy low; its single result
// appears for one cycle with o_done and cannot be held off. After reset the store is
// swept to zero, one pixel a cycle, over all MAX_WIDTH*MAX_HEIGHT addresses with busy
// high; a clear command runs the same sweep and then reaches S_DONE. A new line goes
// straight to S_DONE, a read through S_RD1 and S_RD2, a plot without fill S_MX to S_CHK.
// A fill adds the shared 32x32 multiplier passes of S_BM, the square root for diagonal
// gaps (S_SQ1 to S_SQE), then per fill pixel S_STEP, the bit-serial blend divider S_DIV
// and S_FW; a gap of d pixels has about d fill pixels on an axis, 2*d on a diagonal.
module polyline_gap_fill_raster #(
    parameter int MAX_WIDTH  = pgf_raster_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pgf_raster_pkg::DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = pgf_raster_pkg::DEF_COLOR_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [7:0]  i_color_red,
    input  logic [7:0]  i_color_green,
    input  logic [7:0]  i_color_blue,
    input  logic [7:0]  i_read_x,
    input  logic [7:0]  i_read_y,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [7:0]  o_pixel_red,
    output logic [7:0]  o_pixel_green,
    output logic [7:0]  o_pixel_blue,
    output logic        o_point_off_screen
);
    import pgf_raster_pkg::*;

    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW    = $clog2(MAXD);
    localparam int AWD   = DW + 1;
    localparam int TW    = DW + 2;
    localparam int PW    = DW + 2;
    localparam int SW    = 2 * DW + 1;
    localparam int CW    = COLOR_BITS;
    localparam int BW    = CW + TW;
    localparam int KW    = $clog2(COLOR_BITS);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [8:0]  r_fw, r_fh;
    logic [31:0] r_scale;

    logic [1:0]  r_cmd;
    logic [31:0] r_cx, r_cy;
    logic [CW-1:0] r_c [3];
    logic [CW-1:0] r_lc [3];
    logic [7:0]  r_rdx, r_rdy;
    logic        r_rpt, r_ok, r_broken;
    logic [AW-1:0] r_clr;
    logic [31:0] r_xmag;
    logic [63:0] r_prod;
    logic [DW-1:0] r_px, r_py, r_lx, r_ly, r_dx, r_dy;
    logic        r_xdec, r_ydec;
    logic [TW-1:0] r_ax, r_ay, r_t, r_den, r_i;
    logic [SW-1:0] r_sq_s, r_sq_r, r_sq_bit;
    logic [1:0]  r_bk;
    logic signed [PW-1:0] r_qx, r_qy;
    logic [TW-1:0] r_rx, r_ry;
    logic [BW-1:0] r_b [3];
    logic [BW-1:0] r_rem [3];
    logic [CW-1:0] r_q [3];
    logic [KW-1:0] r_k;
    logic [7:0]  r_out_r, r_out_g, r_out_b;
    logic        r_out_off;

    logic [3*CW-1:0] mem [DEPTH];
    logic [3*CW-1:0] r_mem_q;

    logic [AWD-1:0] aw, ah;
    logic [31:0] mul_a, mul_b;
    logic        ymag_neg;
    logic [31:0] ymag;
    logic        pt_ok;
    logic [DW-1:0] px_n, py_n, dx_n, dy_n;
    logic        lx_gt, ly_gt, gap;
    logic [SW:0] sq_try;
    logic [TW-1:0] total;
    logic [PW+TW-1:0] stx, sty;
    logic signed [PW-1:0] qtx, qty;
    logic        fill_ok, rd_ok;
    logic [BW-1:0] b_nx [3];
    logic [BW-1:0] trial;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [3*CW-1:0] mem_wd;

    function automatic logic [CW-1:0] to_cw(input logic [7:0] v);
        logic [CW+7:0] t;
        t = {{CW{1'b0}}, v};
        return t[CW-1:0];
    endfunction

    function automatic logic [7:0] to_8(input logic [CW-1:0] v);
        logic [CW+7:0] t;
        t = {8'd0, v};
        return t[7:0];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [PW+TW-1:0] step_pos(input logic signed [PW-1:0] q,
                                                  input logic [TW-1:0] r,
                                                  input logic [TW-1:0] a,
                                                  input logic [TW-1:0] t,
                                                  input logic dec);
        logic [TW:0] sum;
        logic signed [PW-1:0] qn;
        logic [TW-1:0] rn;
        sum = {1'b0, r} + {1'b0, a};
        if (!dec) begin
            if (sum >= {1'b0, t}) begin
                rn = TW'(sum - {1'b0, t});
                qn = q + PW'(1);
            end else begin
                rn = sum[TW-1:0];
                qn = q;
            end
        end else if (r >= a) begin
            rn = r - a;
            qn = q;
        end else begin
            rn = TW'({1'b0, r} + {1'b0, t} - {1'b0, a});
            qn = q - PW'(1);
        end
        return {qn, rn};
    endfunction

    function automatic logic signed [PW-1:0] trunc_pos(input logic signed [PW-1:0] q,
                                                       input logic [TW-1:0] r);
        return (q < 0 && r != '0) ? q + PW'(1) : q;
    endfunction

    always_comb begin
        if (r_fw == 9'd0) begin
            aw = AWD'(1);
        end else if (32'(r_fw) > 32'(MAX_WIDTH)) begin
            aw = AWD'(MAX_WIDTH);
        end else begin
            aw = AWD'(r_fw);
        end
        if (r_fh == 9'd0) begin
            ah = AWD'(1);
        end else if (32'(r_fh) > 32'(MAX_HEIGHT)) begin
            ah = AWD'(MAX_HEIGHT);
        end else begin
            ah = AWD'(r_fh);
        end
    end

    always_comb begin
        ymag     = r_prod[63:32];
        ymag_neg = r_cy[31];
        pt_ok    = (r_cx[31] ? (r_xmag == 32'd0) : (r_xmag < 32'(aw))) &&
                   (ymag_neg ? (ymag == 32'd0) : (ymag < 32'(ah)));
        px_n     = r_xmag[DW-1:0];
        py_n     = ymag[DW-1:0];
        lx_gt    = r_lx > px_n;
        ly_gt    = r_ly > py_n;
        dx_n     = lx_gt ? r_lx - px_n : px_n - r_lx;
        dy_n     = ly_gt ? r_ly - py_n : py_n - r_ly;
        gap      = (dx_n > DW'(1)) || (dy_n > DW'(1));
        sq_try   = {1'b0, r_sq_r} + {1'b0, r_sq_bit};
        total    = {r_sq_r[DW:0], 1'b0};
        stx      = step_pos(r_qx, r_rx, r_ax, r_t, r_xdec);
        sty      = step_pos(r_qy, r_ry, r_ay, r_t, r_ydec);
        qtx      = trunc_pos(r_qx, r_rx);
        qty      = trunc_pos(r_qy, r_ry);
        fill_ok  = !qtx[PW-1] && !qty[PW-1] &&
                   (qtx < $signed({1'b0, aw})) && (qty < $signed({1'b0, ah}));
        rd_ok    = (32'(r_rdx) < 32'(aw)) && (32'(r_rdy) < 32'(ah));
        trial    = BW'(r_den) << r_k;
        for (int ch = 0; ch < 3; ch++) begin
            b_nx[ch] = r_b[ch] + BW'(r_c[ch]) - BW'(r_lc[ch]);
        end
        mem_ra   = AW'(32'(r_rdy) * 32'(MAX_WIDTH) + 32'(r_rdx));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_command)
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_LINE:  n_state = S_DONE;
                        CMD_PLOT:  n_state = S_MX;
                        CMD_READ:  n_state = S_RD1;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_CLR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = r_rpt ? S_DONE : S_IDLE;
                end
            end
            S_MX:  n_state = S_MY;
            S_MY:  n_state = S_CHK;
            S_CHK: begin
                priority if (!pt_ok || r_broken || !gap) begin
                    n_state = S_DONE;
                end else if (dx_n == '0 || dy_n == '0) begin
                    n_state = S_BM;
                end else begin
                    n_state = S_SQ1;
                end
            end
            S_SQ1: n_state = S_SQ2;
            S_SQ2: n_state = S_SQ3;
            S_SQ3: n_state = S_SQRT;
            S_SQRT: begin
                if (r_sq_bit == SW'(1)) begin
                    n_state = S_SQE;
                end
            end
            S_SQE: n_state = S_BM;
            S_BM: begin
                if (r_bk == 2'd3) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: n_state = S_DIV;
            S_DIV: begin
                if (r_k == '0) begin
                    n_state = S_FW;
                end
            end
            S_FW:  n_state = (r_i == r_den - TW'(1)) ? S_DONE : S_STEP;
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy   = (r_state != S_IDLE);
        o_done = (r_state == S_DONE);
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_MX: begin
                mul_a = abs32(r_cx);
                mul_b = r_scale;
            end
            S_MY: begin
                mul_a = abs32(r_cy);
                mul_b = r_scale;
            end
            S_CHK: begin
                mem_we = pt_ok;
                mem_wa = AW'(32'(py_n) * 32'(MAX_WIDTH) + 32'(px_n));
                mem_wd = {r_c[0], r_c[1], r_c[2]};
            end
            S_SQ1: begin
                mul_a = 32'(r_dx);
                mul_b = 32'(r_dx);
            end
            S_SQ2: begin
                mul_a = 32'(r_dy);
                mul_b = 32'(r_dy);
            end
            S_BM: begin
                mul_b = 32'(r_den);
                unique case (r_bk)
                    2'd0:    mul_a = 32'(r_lc[0]);
                    2'd1:    mul_a = 32'(r_lc[1]);
                    2'd2:    mul_a = 32'(r_lc[2]);
                    default: mul_a = '0;
                endcase
            end
            S_FW: begin
                mem_we = fill_ok;
                mem_wa = AW'(32'(qty[DW-1:0]) * 32'(MAX_WIDTH) + 32'(qtx[DW-1:0]));
                mem_wd = {r_q[0], r_q[1], r_q[2]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_rpt    <= 1'b0;
            r_ok     <= 1'b0;
            r_broken <= 1'b1;
            r_lx     <= '0;
            r_ly     <= '0;
            r_lc     <= '{default: '0};
            r_fw     <= RST_FRAME_WIDTH;
            r_fh     <= RST_FRAME_HEIGHT;
            r_scale  <= RST_PIXEL_SCALE;
            r_bk     <= '0;
            r_k      <= '0;
            r_i      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FRAME_WIDTH:  r_fw <= i_cfg_data[8:0];
                    REG_FRAME_HEIGHT: r_fh <= i_cfg_data[8:0];
                    REG_PIXEL_SCALE:  r_scale <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd     <= i_command;
                        r_cx      <= i_coord_x;
                        r_cy      <= i_coord_y;
                        r_c[0]    <= to_cw(i_color_red);
                        r_c[1]    <= to_cw(i_color_green);
                        r_c[2]    <= to_cw(i_color_blue);
                        r_rdx     <= i_read_x;
                        r_rdy     <= i_read_y;
                        r_rpt     <= 1'b1;
                        r_ok      <= 1'b0;
                        r_clr     <= '0;
                        r_out_r   <= '0;
                        r_out_g   <= '0;
                        r_out_b   <= '0;
                        r_out_off <= 1'b0;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                end
                S_MY: begin
                    r_xmag <= r_prod[63:32];
                end
                S_CHK: begin
                    r_ok      <= pt_ok;
                    r_out_off <= !pt_ok;
                    r_px      <= px_n;
                    r_py      <= py_n;
                    r_dx      <= dx_n;
                    r_dy      <= dy_n;
                    r_xdec    <= lx_gt;
                    r_ydec    <= ly_gt;
                    r_bk      <= '0;
                    r_t       <= TW'(1);
                    if (dx_n == '0) begin
                        r_den <= TW'(dy_n);
                        r_ax  <= '0;
                        r_ay  <= TW'(1);
                    end else begin
                        r_den <= TW'(dx_n);
                        r_ax  <= TW'(1);
                        r_ay  <= '0;
                    end
                end
                S_SQ2: begin
                    r_sq_s <= r_prod[SW-1:0];
                end
                S_SQ3: begin
                    r_sq_s   <= r_sq_s + r_prod[SW-1:0];
                    r_sq_r   <= '0;
                    r_sq_bit <= SW'(1) << (SW - 1);
                end
                S_SQRT: begin
                    if ({1'b0, r_sq_s} >= sq_try) begin
                        r_sq_s <= SW'({1'b0, r_sq_s} - sq_try);
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                end
                S_SQE: begin
                    r_den <= total;
                    r_t   <= total - TW'(1);
                    r_ax  <= TW'(r_dx) + TW'(1);
                    r_ay  <= TW'(r_dy);
                    r_bk  <= '0;
                end
                S_BM: begin
                    r_bk <= r_bk + 2'd1;
                    unique case (r_bk)
                        2'd0: begin
                            r_i  <= '0;
                            r_qx <= PW'(r_lx);
                            r_qy <= PW'(r_ly);
                            r_rx <= '0;
                            r_ry <= '0;
                        end
                        2'd1:    r_b[0] <= r_prod[BW-1:0];
                        2'd2:    r_b[1] <= r_prod[BW-1:0];
                        default: r_b[2] <= r_prod[BW-1:0];
                    endcase
                end
                S_STEP: begin
                    r_i  <= r_i + TW'(1);
                    r_qx <= stx[PW+TW-1:TW];
                    r_rx <= stx[TW-1:0];
                    r_qy <= sty[PW+TW-1:TW];
                    r_ry <= sty[TW-1:0];
                    r_k  <= KW'(CW - 1);
                    for (int ch = 0; ch < 3; ch++) begin
                        r_b[ch]   <= b_nx[ch];
                        r_rem[ch] <= b_nx[ch];
                        r_q[ch]   <= '0;
                    end
                end
                S_DIV: begin
                    r_k <= r_k - KW'(1);
                    for (int ch = 0; ch < 3; ch++) begin
                        if (r_rem[ch] >= trial) begin
                            r_rem[ch] <= r_rem[ch] - trial;
                            r_q[ch]   <= {r_q[ch][CW-2:0], 1'b1};
                        end else begin
                            r_q[ch]   <= {r_q[ch][CW-2:0], 1'b0};
                        end
                    end
                end
                S_RD2: begin
                    if (rd_ok) begin
                        r_out_r <= to_8(r_mem_q[3*CW-1:2*CW]);
                        r_out_g <= to_8(r_mem_q[2*CW-1:CW]);
                        r_out_b <= to_8(r_mem_q[CW-1:0]);
                    end
                end
                S_DONE: begin
                    if (r_cmd == CMD_PLOT && r_ok) begin
                        r_lx     <= r_px;
                        r_ly     <= r_py;
                        r_lc     <= r_c;
                        r_broken <= 1'b0;
                    end else if (r_cmd != CMD_READ) begin
                        r_broken <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_pixel_red        = r_out_r;
    assign o_pixel_green      = r_out_g;
    assign o_pixel_blue       = r_out_b;
    assign o_point_off_screen = r_out_off;

`include "polyline_gap_fill_raster_assert.svh"

    `PGF_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `PGF_ASSERT_NOW(a_off_only_plot, i_clk, i_rst_n,
        o_done && o_point_off_screen, r_cmd == CMD_PLOT)
    `PGF_ASSERT_NOW(a_zero_unless_read, i_clk, i_rst_n, o_done && r_cmd != CMD_READ,
        (o_pixel_red == 8'd0 && o_pixel_green == 8'd0 && o_pixel_blue == 8'd0))

endmodule

// ----- test/tb_polyline_gap_fill_raster.sv -----
// Self-checking testbench for the polyline gap fill plotter: directed, config and random beats.
`timescale 1ns / 1ps
module tb_polyline_gap_fill_raster;
    import pgf_raster_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  rx;
        logic [7:0]  ry;
    } t_cmd;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       off;
    } t_pixel_out;

    localparam int WATCHDOG_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = CMD_LINE;
    logic [31:0] i_coord_x = '0;
    logic [31:0] i_coord_y = '0;
    logic [7:0]  i_color_red = '0;
    logic [7:0]  i_color_green = '0;
    logic [7:0]  i_color_blue = '0;
    logic [7:0]  i_read_x = '0;
    logic [7:0]  i_read_y = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_FRAME_WIDTH;
    logic [31:0] i_cfg_data = '0;
    logic        o_done;
    logic [7:0]  o_pixel_red;
    logic [7:0]  o_pixel_green;
    logic [7:0]  o_pixel_blue;
    logic        o_point_off_screen;

    polyline_gap_fill_raster dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [23:0] shadow_store [0:65535];
    logic [8:0]  shadow_width = RST_FRAME_WIDTH;
    logic [8:0]  shadow_height = RST_FRAME_HEIGHT;
    logic [31:0] shadow_scale = RST_PIXEL_SCALE;
    bit          pen_up = 1'b1;
    longint      pen_x = 0;
    longint      pen_y = 0;
    logic [23:0] pen_color = '0;

    t_pixel_out  pending_pixels [$];
    int          idle_pct = 0;
    int          fail_count = 0;
    int          stall_cycles = 0;
    int          n_plot = 0, n_fill = 0, n_read = 0, n_clear = 0, n_off = 0, n_results = 0;
    longint      aim_x = 0, aim_y = 0;

    function automatic longint active_w();
        if (shadow_width == 0) return 1;
        if (shadow_width > 256) return 256;
        return shadow_width;
    endfunction

    function automatic longint active_h();
        if (shadow_height == 0) return 1;
        if (shadow_height > 256) return 256;
        return shadow_height;
    endfunction

    function automatic bit on_frame(longint x, longint y);
        return x >= 0 && y >= 0 && x < active_w() && y < active_h();
    endfunction

    function automatic longint pixel_of(logic [31:0] raw);
        longint unsigned mag;
        mag = raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
        mag = (mag * {32'd0, shadow_scale}) >> 32;
        return raw[31] ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic void paint(longint x, longint y, logic [23:0] c);
        if (on_frame(x, y)) shadow_store[y * 256 + x] = c;
    endfunction

    function automatic void paint_blend(longint x, longint y, logic [23:0] c,
                                        longint num, longint den);
        logic [23:0] mix;
        for (int k = 0; k < 3; k++)
            mix[k*8 +: 8] = 8'((longint'(c[k*8 +: 8]) * num
                             + longint'(pen_color[k*8 +: 8]) * (den - num)) / den);
        paint(x, y, mix);
    endfunction

    function automatic void fill_between(longint px, longint py, logic [23:0] c);
        longint dx, dy, total, t, sx, sy, root;
        dx = pen_x > px ? pen_x - px : px - pen_x;
        dy = pen_y > py ? pen_y - py : py - pen_y;
        if (dx <= 1 && dy <= 1) return;
        n_fill++;
        if (dx == 0) begin
            for (longint i = 1; i < dy; i++)
                paint_blend(px, pen_y <= py ? pen_y + i : pen_y - i, c, i, dy);
        end else if (dy == 0) begin
            for (longint i = 1; i < dx; i++)
                paint_blend(pen_x <= px ? pen_x + i : pen_x - i, py, c, i, dx);
        end else begin
            root = 0;
            while ((root + 1) * (root + 1) <= dx * dx + dy * dy) root++;
            total = 2 * root;
            t = total - 1;
            sx = pen_x > px ? -(dx + 1) : dx + 1;
            sy = pen_y > py ? -dy : dy;
            for (longint i = 1; i < total; i++)
                paint_blend((pen_x * t + sx * i) / t, (pen_y * t + sy * i) / t, c, i, total);
        end
    endfunction

    function automatic t_pixel_out predict_pixels(t_cmd c);
        t_pixel_out o;
        longint px, py;
        o = '0;
        case (c.cmd)
            CMD_CLEAR: begin
                for (int a = 0; a < 65536; a++) shadow_store[a] = '0;
                pen_up = 1'b1;
                n_clear++;
            end
            CMD_LINE: pen_up = 1'b1;
            CMD_PLOT: begin
                px = pixel_of(c.x);
                py = pixel_of(c.y);
                n_plot++;
                if (!on_frame(px, py)) begin
                    pen_up = 1'b1;
                    o.off = 1'b1;
                    n_off++;
                end else begin
                    paint(px, py, {c.b, c.g, c.r});
                    if (!pen_up) fill_between(px, py, {c.b, c.g, c.r});
                    pen_x = px;
                    pen_y = py;
                    pen_color = {c.b, c.g, c.r};
                    pen_up = 1'b0;
                end
            end
            default: begin
                n_read++;
                if (on_frame(c.rx, c.ry))
                    {o.b, o.g, o.r} = shadow_store[int'(c.ry) * 256 + int'(c.rx)];
            end
        endcase
        return o;
    endfunction

    task automatic send_cmd(t_cmd c);
        start         <= 1'b1;
        i_command     <= c.cmd;
        i_coord_x     <= c.x;
        i_coord_y     <= c.y;
        i_color_red   <= c.r;
        i_color_green <= c.g;
        i_color_blue  <= c.b;
        i_read_x      <= c.rx;
        i_read_y      <= c.ry;
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back(predict_pixels(c));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        while (busy) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  shadow_width = data[8:0];
            REG_FRAME_HEIGHT: shadow_height = data[8:0];
            REG_PIXEL_SCALE:  shadow_scale = data;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] coord_for(longint p);
        longint unsigned s, mag;
        s = shadow_scale;
        if (s == 0) return $urandom;
        mag = ((longint'(p < 0 ? -p : p)) << 32) + $urandom_range(0, 255) * (s / 256);
        mag = mag / s;
        return p < 0 ? 32'd0 - mag[31:0] : mag[31:0];
    endfunction

    function automatic t_cmd plot_at(longint x, longint y);
        t_cmd c;
        c = '0;
        c.cmd = CMD_PLOT;
        c.x = coord_for(x);
        c.y = coord_for(y);
        {c.r, c.g, c.b} = 24'($urandom);
        return c;
    endfunction

    function automatic t_cmd read_at(longint x, longint y);
        t_cmd c;
        c = '0;
        c.cmd = CMD_READ;
        c.rx = x[7:0];
        c.ry = y[7:0];
        return c;
    endfunction

    function automatic t_cmd simple_cmd(logic [1:0] op);
        t_cmd c;
        c = '0;
        c.cmd = op;
        return c;
    endfunction

    task automatic test_directed();
        t_cmd c;
        send_cmd(read_at(0, 0));
        send_cmd(plot_at(10, 10));
        send_cmd(plot_at(20, 10));
        send_cmd(plot_at(5, 10));
        send_cmd(plot_at(5, 30));
        send_cmd(plot_at(5, 12));
        send_cmd(plot_at(15, 20));
        send_cmd(plot_at(2, 4));
        send_cmd(read_at(12, 10));
        send_cmd(read_at(5, 20));
        c = plot_at(0, 0);
        c.x = 32'h7fff_ffff;
        send_cmd(c);
        c.x = 32'h8000_0000;
        c.y = 32'h8000_0000;
        send_cmd(c);
        c.x = 32'hffff_8000;
        c.y = 32'h0000_0000;
        {c.r, c.g, c.b} = 24'hffffff;
        send_cmd(c);
        send_cmd(simple_cmd(CMD_LINE));
        send_cmd(plot_at(255, 255));
        send_cmd(plot_at(0, 0));
        send_cmd(read_at(255, 255));
        send_cmd(read_at(128, 128));
        send_cmd(simple_cmd(CMD_CLEAR));
        send_cmd(read_at(128, 128));
        send_cmd(read_at(0, 0));
    endtask

    task automatic test_registers();
        write_reg(REG_FRAME_WIDTH, 32'h0);
        write_reg(REG_FRAME_HEIGHT, 32'h1ff);
        send_cmd(plot_at(0, 3));
        send_cmd(plot_at(0, 250));
        send_cmd(plot_at(1, 10));
        send_cmd(read_at(0, 100));
        send_cmd(read_at(1, 10));
        write_reg(REG_FRAME_WIDTH, 32'hffff_fe01);
        write_reg(REG_FRAME_HEIGHT, 32'd1);
        send_cmd(plot_at(255, 0));
        send_cmd(plot_at(0, 0));
        send_cmd(plot_at(4, 1));
        send_cmd(read_at(100, 0));
        write_reg(REG_PIXEL_SCALE, 32'h0);
        send_cmd(plot_at(77, 99));
        send_cmd(read_at(0, 0));
        write_reg(REG_PIXEL_SCALE, 32'hffff_ffff);
        write_reg(REG_FRAME_HEIGHT, 32'd256);
        send_cmd(plot_at(3, 3));
        send_cmd(plot_at(200, 9));
        write_reg(REG_PIXEL_SCALE, RST_PIXEL_SCALE);
        send_cmd(plot_at(40, 40));
        write_reg(REG_FRAME_WIDTH, 32'd30);
        write_reg(REG_FRAME_HEIGHT, 32'd50);
        send_cmd(plot_at(10, 10));
        send_cmd(read_at(35, 38));
        send_cmd(read_at(20, 20));
    endtask

    task automatic test_random(int count);
        t_cmd c;
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 999);
            if (roll < 2) begin
                c = simple_cmd(CMD_CLEAR);
            end else if (roll < 30) begin
                c = {2'(CMD_PLOT + $urandom_range(0, 1)), 32'($urandom), 32'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom)};
            end else if (roll < 90) begin
                c = simple_cmd(CMD_LINE);
            end else if (roll < 450) begin
                if ($urandom_range(0, 9) < 7)
                    c = read_at(aim_x + $urandom_range(0, 6) - 3, aim_y + $urandom_range(0, 6) - 3);
                else
                    c = read_at($urandom_range(0, 255), $urandom_range(0, 255));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    aim_x = longint'($urandom_range(0, 300)) - 20;
                    aim_y = longint'($urandom_range(0, 300)) - 20;
                end else if (roll < 18) begin
                    aim_x += longint'($urandom_range(0, 40)) - 20;
                    aim_y += longint'($urandom_range(0, 40)) - 20;
                end else begin
                    aim_x += longint'($urandom_range(0, 6)) - 3;
                    aim_y += longint'($urandom_range(0, 6)) - 3;
                end
                if (aim_x < -5 || aim_x > active_w() + 5) aim_x = active_w() / 2;
                if (aim_y < -5 || aim_y > active_h() + 5) aim_y = active_h() / 2;
                c = plot_at(aim_x, aim_y);
            end
            send_cmd(c);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_pixels.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_red !== want.r) begin
                    $error("pixel_red expected %0d actual %0d", want.r, o_pixel_red);
                    fail_count++;
                end
                if (o_pixel_green !== want.g) begin
                    $error("pixel_green expected %0d actual %0d", want.g, o_pixel_green);
                    fail_count++;
                end
                if (o_pixel_blue !== want.b) begin
                    $error("pixel_blue expected %0d actual %0d", want.b, o_pixel_blue);
                    fail_count++;
                end
                if (o_point_off_screen !== want.off) begin
                    $error("point_off_screen expected %0d actual %0d", want.off,
                           o_point_off_screen);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n || i_cfg_we) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_polyline_gap_fill_raster NOT OK");
            $finish;
        end
    end

    initial begin
        for (int a = 0; a < 65536; a++) shadow_store[a] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_registers();
        write_reg(REG_FRAME_WIDTH, 32'd256);
        write_reg(REG_FRAME_HEIGHT, 32'd256);
        write_reg(REG_PIXEL_SCALE, RST_PIXEL_SCALE);
        idle_pct = 11;
        test_random(540);
        write_reg(REG_FRAME_WIDTH, 32'd120);
        write_reg(REG_FRAME_HEIGHT, 32'd70);
        write_reg(REG_PIXEL_SCALE, 32'h0001_8000);
        idle_pct = 79;
        test_random(530);
        write_reg(REG_FRAME_WIDTH, 32'd256);
        write_reg(REG_FRAME_HEIGHT, 32'd256);
        write_reg(REG_PIXEL_SCALE, 32'h0000_8000);
        idle_pct = 0;
        test_random(530);
        drain();
        $display("covered %0d plots (%0d gap fills, %0d off frame), %0d reads, %0d clears",
                 n_plot, n_fill, n_off, n_read, n_clear);
        $display("%0d result beats checked, %0d mismatches", n_results, fail_count);
        if (fail_count == 0) begin
            $display("tb_polyline_gap_fill_raster OK");
        end else begin
            $display("tb_polyline_gap_fill_raster NOT OK");
        end
        $finish;
    end

endmodule
